// File: rtl/irt_pkg.sv
`timescale 1ns / 1ps

package irt_pkg;

    localparam int NUM_ROOMS      = 8;
    localparam int SLOTS_PER_ROOM = 16;

    localparam int TIME_W     = 32;
    localparam int ID_W       = 32;
    localparam int ROOM_IDX_W = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
    localparam int SLOT_W     = $clog2(SLOTS_PER_ROOM);
    localparam int CNT_W      = $clog2(SLOTS_PER_ROOM + 1);
    localparam int DEPTH      = NUM_ROOMS * SLOTS_PER_ROOM;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int ENTRY_W    = 2 * TIME_W + ID_W;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_OVERLAP = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan;
        logic    prep;
        logic    shift;
        logic    insert;
        logic    respond;
        status_t resp_status;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic free;
        logic book;
        logic full;
        logic room_bad;
        logic shift_done;
    } ctl_stat_t;

    function automatic logic [ADDR_W-1:0] slot_addr(
        input logic [ROOM_IDX_W-1:0] r,
        input logic [SLOT_W-1:0]     s
    );
        logic [ADDR_W+SLOT_W+ROOM_IDX_W-1:0] a;
        begin
            a = (ADDR_W+SLOT_W+ROOM_IDX_W)'(r) * (ADDR_W+SLOT_W+ROOM_IDX_W)'(SLOTS_PER_ROOM)
                + (ADDR_W+SLOT_W+ROOM_IDX_W)'(s);
            slot_addr = a[ADDR_W-1:0];
        end
    endfunction

endpackage

// File: rtl/irt_ctrl.sv
`timescale 1ns / 1ps

module irt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  irt_pkg::ctl_stat_t stat,
    output irt_pkg::ctl_cmd_t  cmd
);
    import irt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_INSERT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.resp_status = STATUS_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.room_bad)
                    begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = STATUS_FULL;
                        state_next      = ST_IDLE;
                    end
                    else if (!stat.free)
                    begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = STATUS_OVERLAP;
                        state_next      = ST_IDLE;
                    end
                    else if (!stat.book)
                    begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = STATUS_OK;
                        state_next      = ST_IDLE;
                    end
                    else if (stat.full)
                    begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = STATUS_FULL;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        cmd.prep   = 1'b1;
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// File: rtl/irt_datapath.sv
`timescale 1ns / 1ps

module irt_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  irt_pkg::ctl_cmd_t                   cmd,
    output irt_pkg::ctl_stat_t                  stat,
    input  logic                                req_type,
    input  logic [2:0]                          room,
    input  logic [irt_pkg::TIME_W-1:0]          start_time,
    input  logic [irt_pkg::TIME_W-1:0]          end_time,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [irt_pkg::ID_W-1:0]            meeting_id
);
    import irt_pkg::*;

    // Booking store: {number, end, start}
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [CNT_W-1:0]      count_reg [NUM_ROOMS];
    logic [ID_W-1:0]       last_reg;
    logic [ID_W-1:0]       last_next;

    logic                  book_reg;
    logic                  room_bad_reg;
    logic [ROOM_IDX_W-1:0] room_reg;
    logic [TIME_W-1:0]     s_reg;
    logic [TIME_W-1:0]     e_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_dec;
    logic                  pend_reg;
    logic [SLOT_W-1:0]     pend_idx_reg;
    logic                  found_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic                  prev_valid_reg;
    logic [TIME_W-1:0]     prev_end_reg;
    logic [TIME_W-1:0]     next_start_reg;

    logic                  done_reg;
    status_t               status_reg;
    logic [ID_W-1:0]       id_reg;

    logic [ROOM_IDX_W-1:0] room_idx;
    logic                  room_bad_in;
    logic [CNT_W-1:0]      pos_eff;
    logic                  scan_issue;
    logic                  shift_issue;
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_slot;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_slot;
    logic [ENTRY_W-1:0]    wr_data;
    logic [TIME_W-1:0]     rd_start;
    logic [TIME_W-1:0]     rd_end;

    assign room_idx    = ROOM_IDX_W'(room);
    assign room_bad_in = (32'(room) >= 32'(NUM_ROOMS));
    assign pos_eff     = found_reg ? pos_reg : n_reg;
    assign idx_dec     = idx_reg - CNT_W'(1);
    assign last_next   = last_reg + ID_W'(1);
    assign rd_start    = rdata_reg[TIME_W-1:0];
    assign rd_end      = rdata_reg[2*TIME_W-1:TIME_W];

    assign scan_issue  = cmd.scan && !found_reg && (idx_reg < n_reg);
    assign shift_issue = cmd.shift && (idx_reg > pos_eff);
    assign rd_en       = scan_issue || shift_issue;
    assign rd_slot     = scan_issue ? idx_reg[SLOT_W-1:0] : idx_dec[SLOT_W-1:0];

    assign wr_en   = (cmd.shift && pend_reg) || cmd.insert;
    assign wr_slot = cmd.insert ? pos_eff[SLOT_W-1:0] : pend_idx_reg;
    assign wr_data = cmd.insert ? {last_next, e_reg, s_reg} : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot_addr(room_reg, wr_slot)] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[slot_addr(room_reg, rd_slot)];
        end
    end

    // Request payload and scan results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            book_reg     <= req_type;
            room_bad_reg <= room_bad_in;
            room_reg     <= room_idx;
            s_reg        <= (start_time > end_time) ? end_time : start_time;
            e_reg        <= (start_time > end_time) ? start_time : end_time;
            n_reg        <= room_bad_in ? '0 : count_reg[room_idx];
        end
        if (cmd.scan && pend_reg && !found_reg)
        begin
            if (rd_start >= s_reg)
            begin
                pos_reg        <= CNT_W'(pend_idx_reg);
                next_start_reg <= rd_start;
            end
            else
            begin
                prev_end_reg <= rd_end;
            end
        end
        if (rd_en)
        begin
            pend_idx_reg <= idx_reg[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            prev_valid_reg <= 1'b0;
            last_reg       <= '0;
            done_reg       <= 1'b0;
            status_reg     <= STATUS_OK;
            id_reg         <= '0;
            for (int i = 0; i < NUM_ROOMS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg        <= '0;
                pend_reg       <= 1'b0;
                found_reg      <= 1'b0;
                prev_valid_reg <= 1'b0;
            end
            else if (cmd.prep)
            begin
                idx_reg  <= n_reg;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan || cmd.shift)
            begin
                pend_reg <= rd_en;
                if (scan_issue)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                else if (shift_issue)
                begin
                    idx_reg <= idx_dec;
                end
            end

            if (cmd.scan && pend_reg && !found_reg)
            begin
                if (rd_start >= s_reg)
                begin
                    found_reg <= 1'b1;
                end
                else
                begin
                    prev_valid_reg <= 1'b1;
                end
            end

            if (cmd.insert)
            begin
                last_reg            <= last_next;
                count_reg[room_reg] <= n_reg + CNT_W'(1);
            end

            done_reg <= cmd.respond || cmd.insert;
            if (cmd.insert)
            begin
                status_reg <= STATUS_OK;
                id_reg     <= last_next;
            end
            else if (cmd.respond)
            begin
                status_reg <= cmd.resp_status;
                id_reg     <= '0;
            end
        end
    end

    assign stat.scan_done  = found_reg || ((idx_reg >= n_reg) && !pend_reg);
    assign stat.free       = !(found_reg && (e_reg > next_start_reg))
                             && !(prev_valid_reg && (s_reg < prev_end_reg));
    assign stat.book       = book_reg;
    assign stat.full       = (n_reg == CNT_W'(SLOTS_PER_ROOM));
    assign stat.room_bad   = room_bad_reg;
    assign stat.shift_done = (idx_reg <= pos_eff) && !pend_reg;

    assign done       = done_reg;
    assign status     = status_reg;
    assign meeting_id = id_reg;

endmodule

// File: rtl/interval_reservation_table_core.sv
`timescale 1ns / 1ps
// Flow: a check scans the resource's entries and then gives its result; a booking adds
//   a shift pass that moves the entries from its position up by one, and an insert step.
// Throughput: one transaction at a time; the next start is taken in the cycle done is shown.
//   Time per transaction is set by the walk over one resource's sorted entries.
// Reset: rst_n clears all booking counts and the meeting counter; no clearing pass is needed.
// The done strobe lasts one cycle and cannot be stalled by the receiver.

module interval_reservation_table_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         req_type,
    input  logic [2:0]                   room,
    input  logic [irt_pkg::TIME_W-1:0]   start_time,
    input  logic [irt_pkg::TIME_W-1:0]   end_time,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [irt_pkg::ID_W-1:0]     meeting_id
);
    import irt_pkg::*;

    // Command and status between the sequencer and the booking datapath.
    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // Sequencer: accept a transaction, walk the resource's entries in start order
    // until the first start at or after the request start, decide, then shift the
    // tail up by one entry and drop the new booking into its sorted slot.
    irt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Datapath: booking store (one write and one registered read port), per-resource
    // counts, meeting counter, overlap test and the result register.
    irt_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req_type),
        .room       (room),
        .start_time (start_time),
        .end_time   (end_time),
        .done       (done),
        .status     (status),
        .meeting_id (meeting_id)
    );

    // A result is shown only once the block is ready for the next transaction.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done asserted while busy");

    // An accepted transaction always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Only a successful booking carries a meeting number.
    a_id_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (meeting_id == '0))
        else $error("meeting number given on a failed transaction");

    // Two results never come back to back: each transaction passes through the scan state first.
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on consecutive cycles");

endmodule

// File: tb/tb_interval_reservation_table_core.sv
`timescale 1ns / 1ps

module tb_interval_reservation_table_core;
    import irt_pkg::*;

    localparam bit REQ_CHECK    = 1'b0;
    localparam bit REQ_BOOK     = 1'b1;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;

    // Track the per-room sorted bookings and predict each transaction's result.
    class booking_scoreboard;
        typedef struct {
            status_t     status;
            logic [31:0] meeting_id;
        } booking_result_t;

        logic [TIME_W-1:0] slot_begin [NUM_ROOMS][SLOTS_PER_ROOM];
        logic [TIME_W-1:0] slot_finish[NUM_ROOMS][SLOTS_PER_ROOM];
        logic [ID_W-1:0]   slot_id    [NUM_ROOMS][SLOTS_PER_ROOM];
        int unsigned       room_fill  [NUM_ROOMS];
        logic [ID_W-1:0]   last_id;
        booking_result_t   awaited[$];
        int                errors;

        function new();
            for (int r = 0; r < NUM_ROOMS; r++)
            begin
                room_fill[r] = 0;
            end
            last_id = '0;
            errors  = 0;
        endfunction

        function void note_request(logic book, logic [2:0] r,
                                   logic [TIME_W-1:0] s_in, logic [TIME_W-1:0] e_in);
            logic [TIME_W-1:0] s;
            logic [TIME_W-1:0] e;
            int unsigned       pos;
            int unsigned       cnt;
            bit                open;
            booking_result_t   res;
            s = s_in;
            e = e_in;
            res.status     = STATUS_OK;
            res.meeting_id = '0;
            // Swap reversed bounds first.
            if (s > e)
            begin
                s = e_in;
                e = s_in;
            end
            if (r >= NUM_ROOMS)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                cnt = room_fill[r];
                pos = cnt;
                for (int i = cnt - 1; i >= 0; i--)
                begin
                    if (slot_begin[r][i] >= s)
                        pos = i;
                end
                open = 1'b1;
                if (pos < cnt && e > slot_begin[r][pos])
                    open = 1'b0;
                if (pos > 0 && s < slot_finish[r][pos-1])
                    open = 1'b0;
                if (!open)
                    res.status = STATUS_OVERLAP;
                else if (book)
                begin
                    if (cnt >= SLOTS_PER_ROOM)
                        res.status = STATUS_FULL;
                    else
                    begin
                        for (int i = cnt; i > pos; i--)
                        begin
                            slot_begin[r][i]  = slot_begin[r][i-1];
                            slot_finish[r][i] = slot_finish[r][i-1];
                            slot_id[r][i]     = slot_id[r][i-1];
                        end
                        last_id           = last_id + 1;
                        slot_begin[r][pos]  = s;
                        slot_finish[r][pos] = e;
                        slot_id[r][pos]     = last_id;
                        room_fill[r]        = cnt + 1;
                        res.meeting_id      = last_id;
                    end
                end
            end
            awaited.insert(awaited.size(), res);
        endfunction

        function void check_result(logic [1:0] st, logic [ID_W-1:0] id);
            booking_result_t res;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: status %0d, meeting_id %0d", st, id);
                errors++;
                return;
            end
            res = awaited.pop_front();
            if (st !== res.status)
            begin
                $error("status: expected %0d, actual %0d", res.status, st);
                errors++;
            end
            if (id !== res.meeting_id)
            begin
                $error("meeting_id: expected %0d, actual %0d", res.meeting_id, id);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              req_type;
    logic [2:0]        room;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              done;
    logic [1:0]        status;
    logic [ID_W-1:0]   meeting_id;

    booking_scoreboard sb;
    int                quiet_cycles;

    interval_reservation_table_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .room       (room),
        .start_time (start_time),
        .end_time   (end_time),
        .done       (done),
        .status     (status),
        .meeting_id (meeting_id)
    );

    always #10 clk = ~clk;

    // Check the finished transaction before noting a new one taken on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
                sb.check_result(status, meeting_id);
            if (start && busy === 1'b0)
                sb.note_request(req_type, room, start_time, end_time);
            if ((start && busy === 1'b0) || done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("interval_reservation_table_core regression: fail");
                $finish;
            end
        end
    end

    // Present one request at the falling edge and hold it until the block takes it.
    task automatic send_request(logic book, logic [2:0] r,
                                logic [TIME_W-1:0] s, logic [TIME_W-1:0] e);
        @(negedge clk);
        start      <= 1'b1;
        req_type   <= book;
        room       <= r;
        start_time <= s;
        end_time   <= e;
        forever
        begin
            @(posedge clk);
            if (busy === 1'b0)
                break;
        end
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                mode;
        logic              book;
        logic [2:0]        r;
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
        logic [TIME_W-1:0] t;

        sb           = new();
        quiet_cycles = 0;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = 1'b0;
        room         = '0;
        start_time   = '0;
        end_time     = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, reversed bounds, zero length, touching and overlapping.
        send_request(REQ_CHECK, 3'd0, 32'd0, 32'd0);
        send_request(REQ_BOOK,  3'd0, 32'hFFFF_FFFF, 32'd0);
        send_request(REQ_BOOK,  3'd0, 32'd0, 32'd0);
        send_request(REQ_BOOK,  3'd1, 32'd100, 32'd200);
        send_request(REQ_BOOK,  3'd1, 32'd200, 32'd300);
        send_request(REQ_BOOK,  3'd1, 32'd100, 32'd50);
        send_request(REQ_BOOK,  3'd1, 32'd150, 32'd150);
        send_request(REQ_CHECK, 3'd1, 32'd300, 32'd300);
        send_request(REQ_CHECK, 3'd1, 32'd199, 32'd201);
        send_request(REQ_BOOK,  3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_CHECK, 3'd2, 32'd0, 32'hFFFF_FFFF);
        // Fill one room in descending order so every insert shifts all of that room's entries.
        for (int i = SLOTS_PER_ROOM - 1; i >= 0; i--)
            send_request(REQ_BOOK, 3'd7, 32'(i * 10), 32'(i * 10 + 10));
        // Full room: a check reports availability only, a free booking reports full.
        send_request(REQ_CHECK, 3'd7, 32'd500, 32'd600);
        send_request(REQ_BOOK,  3'd7, 32'd500, 32'd600);
        send_request(REQ_BOOK,  3'd7, 32'd5, 32'd15);
        wait_drained();

        // Random: mostly dense small windows so bookings touch, overlap and fill rooms.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            mode = $urandom_range(0, 99);
            book = ($urandom_range(0, 9) < 7);
            r    = 3'($urandom_range(0, 7));
            if (mode < 55)
            begin
                s = $urandom_range(0, 400);
                e = s + $urandom_range(0, 30);
            end
            else if (mode < 70)
            begin
                s    = $urandom;
                e    = $urandom;
                book = 1'($urandom_range(0, 1));
            end
            else if (mode < 85)
            begin
                s = 32'hFFFF_FFFF - $urandom_range(0, 60);
                e = 32'hFFFF_FFFF - $urandom_range(0, 60);
            end
            else
            begin
                s = $urandom_range(0, 40);
                e = s + $urandom_range(0, 3);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                t = s;
                s = e;
                e = t;
            end
            send_request(book, r, s, e);
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            else if (n < RANDOM_ITEMS - 100 && $urandom_range(0, 2) == 0)
                idle_cycles($urandom_range(1, 11));
        end

        // Drop start, drain outstanding results, then let the block settle.
        idle_cycles(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("interval_reservation_table_core regression: pass");
        else
            $display("interval_reservation_table_core regression: fail");
        $finish;
    end

endmodule

// File: interval_reservation_table_core.f
rtl/irt_pkg.sv
rtl/irt_ctrl.sv
rtl/irt_datapath.sv
rtl/interval_reservation_table_core.sv
tb/tb_interval_reservation_table_core.sv
